FILE: rtl/bbst_pkg.sv
// ============================================================================
// bbst_pkg: shared types and constants for the bounding box / sphere unit
// Formats, command codes, register indexes and the payloads passed between
// the pipeline stages.
// ============================================================================
package bbst_pkg;

  localparam int COORD_BITS   = 24;                 // Q12.12 coordinates
  localparam int COEF_BITS    = 16;                 // Q4.12 weights
  localparam int FRAC_BITS    = 12;
  localparam int NUM_AXES     = 3;
  localparam int CFG_BITS     = NUM_AXES * COEF_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int CMD_BITS     = 2;
  localparam int RAD_BITS     = COORD_BITS - 1;

  localparam int PROD_BITS    = COORD_BITS + COEF_BITS;
  localparam int SUM_BITS     = PROD_BITS + 2;
  localparam int DIST_BITS    = COORD_BITS;
  localparam int SQ_BITS      = 2 * DIST_BITS;
  localparam int SQSUM_BITS   = SQ_BITS + 2;
  localparam int RSQ_BITS     = 2 * RAD_BITS;

  localparam int IN_FIELD_BITS  = NUM_AXES * COORD_BITS + RAD_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 + 2 * NUM_AXES * COORD_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_BITS-1:0]          cfg_word_t;

  localparam coord_t    COORD_MAX     = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam coord_t    COORD_MIN     = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});
  localparam cfg_word_t COEF_ONE_WORD = cfg_word_t'(1) << FRAC_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_TEST  = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_Z   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Z = 3'd5;

  // accepted command beat
  typedef struct packed {
    cmd_t                                   cmd;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]    pos;
    logic [RAD_BITS-1:0]                    radius;
  } in_item_t;

  // after the weight products; prod[out_axis][in_axis]
  typedef struct packed {
    cmd_t                                          cmd;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]           pos;
    logic [RAD_BITS-1:0]                           radius;
    logic [NUM_AXES-1:0][NUM_AXES-1:0][PROD_BITS-1:0] prod;
  } xf_item_t;

  // box as reported with one result
  typedef struct packed {
    logic                                empty;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] low;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] high;
  } box_view_t;

  // after the box stage: clamped distances for a test
  typedef struct packed {
    logic                                test_en;
    logic [NUM_AXES-1:0][DIST_BITS-1:0]  gap;
    logic [RAD_BITS-1:0]                 radius;
    box_view_t                           view;
  } bx_item_t;

  // after squaring
  typedef struct packed {
    logic                                test_en;
    logic [NUM_AXES-1:0][SQ_BITS-1:0]    sq;
    logic [RSQ_BITS-1:0]                 rsq;
    box_view_t                           view;
  } sq_item_t;

  typedef struct packed {
    logic      hit;
    box_view_t view;
  } result_t;

endpackage

FILE: rtl/bbst_xform.sv
// ============================================================================
// bbst_xform: weight product stage
// Forms the nine coordinate-by-weight products of the affine transform and
// registers them with the rest of the command beat.
// ============================================================================
module bbst_xform (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                s1_valid,
  output logic                                                s1_ready,
  input  bbst_pkg::in_item_t                                  s1_item,
  input  logic [bbst_pkg::NUM_AXES-1:0][bbst_pkg::CFG_BITS-1:0] coef,
  output logic                                                xf_valid,
  input  logic                                                xf_ready,
  output bbst_pkg::xf_item_t                                  xf_item
);

  logic               xf_valid_r;
  bbst_pkg::xf_item_t xf_item_r;
  bbst_pkg::xf_item_t xf_item_nxt;
  logic               load;

  assign load     = !xf_valid_r || xf_ready;
  assign s1_ready = load;

  always_comb begin
    xf_item_nxt.cmd    = s1_item.cmd;
    xf_item_nxt.pos    = s1_item.pos;
    xf_item_nxt.radius = s1_item.radius;
    for (int o = 0; o < bbst_pkg::NUM_AXES; o++) begin
      for (int i = 0; i < bbst_pkg::NUM_AXES; i++) begin
        xf_item_nxt.prod[o][i] = $signed(s1_item.pos[i]) *
          $signed(coef[o][i*bbst_pkg::COEF_BITS +: bbst_pkg::COEF_BITS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xf_valid_r <= 1'b0;
    end else if (load) begin
      xf_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && s1_valid) begin
      xf_item_r <= xf_item_nxt;
    end
  end

  assign xf_valid = xf_valid_r;
  assign xf_item  = xf_item_r;

endmodule

FILE: rtl/bbst_box.sv
// ============================================================================
// bbst_box: box state stage
// Finishes the transform (offset, rounding, saturation), keeps the running
// box and clamps sphere centers into it.
// ============================================================================
module bbst_box (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   xf_valid,
  output logic                                                   xf_ready,
  input  bbst_pkg::xf_item_t                                     xf_item,
  input  logic [bbst_pkg::NUM_AXES-1:0][bbst_pkg::COORD_BITS-1:0] offset,
  output logic                                                   bx_valid,
  input  logic                                                   bx_ready,
  output bbst_pkg::bx_item_t                                     bx_item
);

  localparam int SB = bbst_pkg::SUM_BITS;
  localparam int CB = bbst_pkg::COORD_BITS;
  localparam logic signed [SB-1:0] HALF = SB'(1) << (bbst_pkg::FRAC_BITS - 1);

  bbst_pkg::coord_t   box_low_r  [bbst_pkg::NUM_AXES];
  bbst_pkg::coord_t   box_high_r [bbst_pkg::NUM_AXES];
  logic               box_empty_r;
  bbst_pkg::coord_t   box_low_nxt  [bbst_pkg::NUM_AXES];
  bbst_pkg::coord_t   box_high_nxt [bbst_pkg::NUM_AXES];
  logic               box_empty_nxt;

  bbst_pkg::coord_t   vert [bbst_pkg::NUM_AXES];
  logic signed [SB-1:0] acc  [bbst_pkg::NUM_AXES];
  logic signed [SB-1:0] scl  [bbst_pkg::NUM_AXES];
  logic signed [SB-1:0] off_ext [bbst_pkg::NUM_AXES];

  bbst_pkg::coord_t   ctr  [bbst_pkg::NUM_AXES];
  bbst_pkg::coord_t   clmp [bbst_pkg::NUM_AXES];
  logic signed [CB:0] diff [bbst_pkg::NUM_AXES];
  logic [CB:0]        mag  [bbst_pkg::NUM_AXES];

  logic               bx_valid_r;
  bbst_pkg::bx_item_t bx_item_r;
  bbst_pkg::bx_item_t bx_item_nxt;
  logic               load;
  logic               step;

  assign load     = !bx_valid_r || bx_ready;
  assign xf_ready = load;
  assign step     = xf_valid && load;

  // transform: sum products and offset, round half up, saturate
  always_comb begin
    for (int o = 0; o < bbst_pkg::NUM_AXES; o++) begin
      off_ext[o] = $signed(offset[o]);
      acc[o] = $signed(xf_item.prod[o][0]) + $signed(xf_item.prod[o][1]) +
               $signed(xf_item.prod[o][2]) + (off_ext[o] <<< bbst_pkg::FRAC_BITS) + HALF;
      scl[o] = acc[o] >>> bbst_pkg::FRAC_BITS;
      if (scl[o][SB-1:CB-1] == '0 || scl[o][SB-1:CB-1] == '1) begin
        vert[o] = scl[o][CB-1:0];
      end else if (scl[o][SB-1]) begin
        vert[o] = bbst_pkg::COORD_MIN;
      end else begin
        vert[o] = bbst_pkg::COORD_MAX;
      end
    end
  end

  // box update
  always_comb begin
    box_empty_nxt = box_empty_r;
    for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
      box_low_nxt[a]  = box_low_r[a];
      box_high_nxt[a] = box_high_r[a];
    end
    case (xf_item.cmd)
      bbst_pkg::CMD_CLEAR: begin
        box_empty_nxt = 1'b1;
        for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
          box_low_nxt[a]  = bbst_pkg::COORD_MAX;
          box_high_nxt[a] = bbst_pkg::COORD_MIN;
        end
      end
      bbst_pkg::CMD_ADD: begin
        box_empty_nxt = 1'b0;
        for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
          if (box_empty_r || vert[a] < box_low_r[a]) begin
            box_low_nxt[a] = vert[a];
          end
          if (box_empty_r || vert[a] > box_high_r[a]) begin
            box_high_nxt[a] = vert[a];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // clamp the center into the box and take the distance per axis
  always_comb begin
    for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
      ctr[a] = $signed(xf_item.pos[a]);
      clmp[a] = ctr[a];
      if (ctr[a] < box_low_r[a]) begin
        clmp[a] = box_low_r[a];
      end
      if (clmp[a] > box_high_r[a]) begin
        clmp[a] = box_high_r[a];
      end
      diff[a] = $signed({ctr[a][CB-1], ctr[a]}) - $signed({clmp[a][CB-1], clmp[a]});
      mag[a]  = diff[a][CB] ? (CB+1)'(-diff[a]) : diff[a];
    end
  end

  always_comb begin
    bx_item_nxt.test_en    = (xf_item.cmd == bbst_pkg::CMD_TEST) && !box_empty_r;
    bx_item_nxt.radius     = xf_item.radius;
    bx_item_nxt.view.empty = box_empty_nxt;
    for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
      bx_item_nxt.gap[a]       = mag[a][bbst_pkg::DIST_BITS-1:0];
      bx_item_nxt.view.low[a]  = box_low_nxt[a];
      bx_item_nxt.view.high[a] = box_high_nxt[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_empty_r <= 1'b1;
      for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
        box_low_r[a]  <= bbst_pkg::COORD_MAX;
        box_high_r[a] <= bbst_pkg::COORD_MIN;
      end
    end else if (step) begin
      box_empty_r <= box_empty_nxt;
      for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
        box_low_r[a]  <= box_low_nxt[a];
        box_high_r[a] <= box_high_nxt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_valid_r <= 1'b0;
    end else if (load) begin
      bx_valid_r <= xf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      bx_item_r <= bx_item_nxt;
    end
  end

  assign bx_valid = bx_valid_r;
  assign bx_item  = bx_item_r;

  // an empty box always holds the cleared bounds
  a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    box_empty_r |-> (box_low_r[0] == bbst_pkg::COORD_MAX && box_low_r[1] == bbst_pkg::COORD_MAX &&
                     box_low_r[2] == bbst_pkg::COORD_MAX && box_high_r[0] == bbst_pkg::COORD_MIN &&
                     box_high_r[1] == bbst_pkg::COORD_MIN && box_high_r[2] == bbst_pkg::COORD_MIN))
    else $error("empty box with stale bounds");

  // a box with vertices never has crossed bounds
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    !box_empty_r |-> (box_low_r[0] <= box_high_r[0] && box_low_r[1] <= box_high_r[1] &&
                      box_low_r[2] <= box_high_r[2]))
    else $error("box minimum above maximum");

  // a live test beat always carries a nonempty box
  a_test_box: assert property (@(posedge clk) disable iff (!rst_n)
    (bx_valid_r && bx_item_r.test_en) |-> !bx_item_r.view.empty)
    else $error("sphere test enabled on an empty box");

endmodule

FILE: rtl/bbst_sphere.sv
// ============================================================================
// bbst_sphere: sphere distance stage
// Squares the clamped distances and the radius, then compares the sum
// against the squared radius into the result register.
// ============================================================================
module bbst_sphere (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               bx_valid,
  output logic               bx_ready,
  input  bbst_pkg::bx_item_t bx_item,
  output logic               res_valid,
  input  logic               res_ready,
  output bbst_pkg::result_t  res
);

  logic               sq_valid_r;
  bbst_pkg::sq_item_t sq_item_r;
  bbst_pkg::sq_item_t sq_item_nxt;
  logic               res_valid_r;
  bbst_pkg::result_t  res_r;
  bbst_pkg::result_t  res_nxt;
  logic [bbst_pkg::SQSUM_BITS-1:0] sq_sum;
  logic               sq_load;
  logic               res_load;

  assign res_load = !res_valid_r || res_ready;
  assign sq_load  = !sq_valid_r || res_load;
  assign bx_ready = sq_load;

  always_comb begin
    sq_item_nxt.test_en = bx_item.test_en;
    sq_item_nxt.view    = bx_item.view;
    sq_item_nxt.rsq     = bbst_pkg::RSQ_BITS'(bx_item.radius) * bbst_pkg::RSQ_BITS'(bx_item.radius);
    for (int a = 0; a < bbst_pkg::NUM_AXES; a++) begin
      sq_item_nxt.sq[a] = bbst_pkg::SQ_BITS'(bx_item.gap[a]) * bbst_pkg::SQ_BITS'(bx_item.gap[a]);
    end
  end

  always_comb begin
    sq_sum = bbst_pkg::SQSUM_BITS'(sq_item_r.sq[0]) + bbst_pkg::SQSUM_BITS'(sq_item_r.sq[1]) +
             bbst_pkg::SQSUM_BITS'(sq_item_r.sq[2]);
    res_nxt.hit  = sq_item_r.test_en && (sq_sum < bbst_pkg::SQSUM_BITS'(sq_item_r.rsq));
    res_nxt.view = sq_item_r.view;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (sq_load) begin
        sq_valid_r <= bx_valid;
      end
      if (res_load) begin
        res_valid_r <= sq_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_load && bx_valid) begin
      sq_item_r <= sq_item_nxt;
    end
    if (res_load && sq_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/bounding_box_build_and_sphere_test_unit.sv
// ============================================================================
// bounding_box_build_and_sphere_test_unit: streaming AABB builder and tester
// Clear / add-vertex / test-sphere commands against a running axis-aligned
// box; every command beat yields one result beat with the box after it.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                           | tuser
//  --------+-----+----------------------------------------------+---------
//  in_     | in  | pos_x, pos_y, pos_z, radius, zero pad        | command
//  out_    | out | hit, is_empty, low_x/y/z, high_x/y/z, pad    | -
//  cfg_    | in  | cfg_wdata: coef_x/y/z (48b) or offset_x/y/z  | -
//
//  Throughput is one beat per cycle while out_tready is high; a result
//  passes the input reg, product reg, box reg, square reg and result reg.
//  The box register loop (sum, round, saturate, min/max) bounds that
//  rate; each stage advances whenever the stage ahead is empty or
//  moving, so bubbles collapse under out_tready stalls.
//  rst_n is synchronous: it empties the box and restores identity weights.
//  Write cfg_ only while no beat is in flight.
//
module bounding_box_build_and_sphere_test_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], radius[94:72], pad
  input  logic [bbst_pkg::IN_DATA_BITS-1:0]     in_tdata,
  // command[1:0]
  input  logic [bbst_pkg::CMD_BITS-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // hit[0], is_empty[1], low_x, low_y, low_z, high_x, high_y, high_z, pad
  output logic [bbst_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  input  logic                                  cfg_we,
  input  logic [bbst_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bbst_pkg::CFG_BITS-1:0]         cfg_wdata
);

  localparam int CB = bbst_pkg::COORD_BITS;
  localparam int NA = bbst_pkg::NUM_AXES;

  // configuration registers
  logic [NA-1:0][bbst_pkg::CFG_BITS-1:0] coef_r;
  logic [NA-1:0][CB-1:0]                 offset_r;

  // input register
  logic               s1_valid_r;
  bbst_pkg::in_item_t s1_item_r;
  bbst_pkg::in_item_t s1_item_nxt;
  logic               s1_ready;

  logic               xf_valid;
  logic               xf_ready;
  bbst_pkg::xf_item_t xf_item;
  logic               bx_valid;
  logic               bx_ready;
  bbst_pkg::bx_item_t bx_item;
  bbst_pkg::result_t  res;

  // register writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        coef_r[a]   <= bbst_pkg::COEF_ONE_WORD << (a * bbst_pkg::COEF_BITS);
        offset_r[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        bbst_pkg::REG_COEF_X:   coef_r[0]   <= cfg_wdata;
        bbst_pkg::REG_COEF_Y:   coef_r[1]   <= cfg_wdata;
        bbst_pkg::REG_COEF_Z:   coef_r[2]   <= cfg_wdata;
        bbst_pkg::REG_OFFSET_X: offset_r[0] <= cfg_wdata[CB-1:0];
        bbst_pkg::REG_OFFSET_Y: offset_r[1] <= cfg_wdata[CB-1:0];
        bbst_pkg::REG_OFFSET_Z: offset_r[2] <= cfg_wdata[CB-1:0];
        default: begin
        end
      endcase
    end
  end

  // unpack the command beat; pad bits drop
  always_comb begin
    s1_item_nxt.cmd    = bbst_pkg::cmd_t'(in_tuser);
    s1_item_nxt.radius = in_tdata[NA*CB +: bbst_pkg::RAD_BITS];
    for (int a = 0; a < NA; a++) begin
      s1_item_nxt.pos[a] = in_tdata[a*CB +: CB];
    end
  end

  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  bbst_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_ready (s1_ready),
    .s1_item  (s1_item_r),
    .coef     (coef_r),
    .xf_valid (xf_valid),
    .xf_ready (xf_ready),
    .xf_item  (xf_item)
  );

  bbst_box u_box (
    .clk      (clk),
    .rst_n    (rst_n),
    .xf_valid (xf_valid),
    .xf_ready (xf_ready),
    .xf_item  (xf_item),
    .offset   (offset_r),
    .bx_valid (bx_valid),
    .bx_ready (bx_ready),
    .bx_item  (bx_item)
  );

  bbst_sphere u_sphere (
    .clk       (clk),
    .rst_n     (rst_n),
    .bx_valid  (bx_valid),
    .bx_ready  (bx_ready),
    .bx_item   (bx_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result beat, pad with zeros
  always_comb begin
    out_tdata    = '0;
    out_tdata[0] = res.hit;
    out_tdata[1] = res.view.empty;
    for (int a = 0; a < NA; a++) begin
      out_tdata[2 + a*CB +: CB]      = res.view.low[a];
      out_tdata[2 + (NA+a)*CB +: CB] = res.view.high[a];
    end
  end

endmodule
